/* hw/rtl/ctp_pkg.sv */
package ctp_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned TICKS_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Highest handle that the handle field can carry.
  localparam int unsigned MAX_HANDLE = (1 << HANDLE_W) - 1;

  localparam int unsigned NUM_TIMERS_DEFAULT = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_REQUEST = 3'd1,
    MODE_UPDATE  = 3'd2,
    MODE_CHECK   = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_COUNTING = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_FAIL     = 2'd3
  } status_e;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic                accept;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  ticks;
  } cell_op_t;

  // What one cell reports back for the current operation.
  typedef struct packed {
    logic [HANDLE_W-1:0] grant_handle;
    logic                hit;
    logic                counting;
  } cell_rsp_t;

endpackage

/* hw/rtl/ctp_if.sv */
interface ctp_in_if;
  logic                           valid;
  logic                           ready;
  logic [ctp_pkg::MODE_W-1:0]     mode;
  logic [ctp_pkg::HANDLE_W-1:0]   handle;
  logic [ctp_pkg::TICKS_W-1:0]    ticks;

  modport source (output valid, output mode, output handle, output ticks, input ready);
  modport sink   (input valid, input mode, input handle, input ticks, output ready);
endinterface

interface ctp_out_if;
  logic                           valid;
  logic                           ready;
  logic [ctp_pkg::HANDLE_W-1:0]   granted_handle;
  logic [ctp_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output granted_handle, output status, input ready);
  modport sink   (input valid, input granted_handle, input status, output ready);
endinterface

/* hw/rtl/ctp_cell.sv */
module ctp_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctp_pkg::cell_op_t   op_i,
  input  logic                search_i,
  output logic                search_o,
  output ctp_pkg::cell_rsp_t  rsp_o
);
  import ctp_pkg::*;

  localparam bit                  Addressable = (CellIdx < MAX_HANDLE);
  localparam logic [HANDLE_W-1:0] CellHandle  =
    Addressable ? HANDLE_W'(CellIdx + 1) : '0;

  logic               in_use_q, in_use_d;
  logic [TICKS_W-1:0] remaining_q, remaining_d;
  logic               grant;
  logic               hit;

  // Lowest free addressable cell takes a request; pass the search on otherwise.
  assign grant    = search_i && !in_use_q && Addressable;
  assign search_o = search_i && !grant;
  assign hit      = Addressable && in_use_q && (op_i.handle == CellHandle);

  assign rsp_o.grant_handle = grant ? CellHandle : '0;
  assign rsp_o.hit          = hit;
  assign rsp_o.counting     = (remaining_q != '0);

  always_comb begin
    in_use_d    = in_use_q;
    remaining_d = remaining_q;
    if (op_i.accept) begin
      unique case (op_i.mode)
        MODE_TICK: begin
          if (in_use_q && remaining_q != '0) remaining_d = remaining_q - 1'b1;
        end
        MODE_REQUEST: begin
          if (grant) begin
            in_use_d    = 1'b1;
            remaining_d = op_i.ticks;
          end
        end
        MODE_UPDATE: begin
          if (hit) remaining_d = op_i.ticks;
        end
        MODE_CLEAR: begin
          in_use_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  // Count is only read while the cell is in use, so it needs no reset.
  always_ff @(posedge clk_i) begin
    remaining_q <= remaining_d;
  end

endmodule

/* hw/rtl/countdown_timer_pool_top.sv */
// Countdown timer pool.
//
// Input channel in_i carries one operation per transaction: mode (tick,
// request, update, check, clear all), a handle and a tick count. Output
// channel out_o returns exactly one result per operation: granted_handle
// and status. Both channels use valid/ready; a transaction completes on a
// rising edge with valid and ready high.
//
// An accepted operation updates the timer cells at that edge and loads
// its result into the output register at the same edge. Throughput is
// one operation per cycle unless out_o stalls; the free-timer search is a
// ripple along the row of timer cells, which sets the cycle time.
//
// Reset frees every timer at once (in-use marks clear); no clearing pass.
// When the receiver stalls, the result holds in the output register and
// in_i.ready drops until out_o.ready frees the register.
module countdown_timer_pool_top #(
  parameter int unsigned NumTimers = ctp_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ctp_in_if.sink   in_i,
  ctp_out_if.source out_o
);
  import ctp_pkg::*;

  cell_op_t            op;
  cell_rsp_t           rsp [NumTimers];
  logic [NumTimers:0]  search;

  logic                any_grant;
  logic [HANDLE_W-1:0] grant_handle;
  logic                hit;
  logic                counting;

  logic                out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0] granted_q, granted_d;
  status_e             status_q, status_d;
  logic                accept;

  // Take a new transaction whenever the output register is empty or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op.accept = accept;
  assign op.mode   = in_i.mode;
  assign op.handle = in_i.handle;
  assign op.ticks  = in_i.ticks;

  // Seed the free-timer search at the first cell.
  assign search[0] = 1'b1;

  for (genvar g = 0; g < NumTimers; g++) begin : g_cell
    ctp_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op),
      .search_i (search[g]),
      .search_o (search[g+1]),
      .rsp_o    (rsp[g])
    );
  end

  // At most one cell grants and at most one cell matches the handle.
  always_comb begin
    grant_handle = '0;
    hit          = 1'b0;
    counting     = 1'b0;
    for (int i = 0; i < NumTimers; i++) begin
      grant_handle = grant_handle | rsp[i].grant_handle;
      hit          = hit | rsp[i].hit;
      counting     = counting | (rsp[i].hit & rsp[i].counting);
    end
  end

  assign any_grant = (grant_handle != '0);

  // Build the result of the accepted operation.
  always_comb begin
    out_valid_d = out_valid_q;
    granted_d   = granted_q;
    status_d    = status_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (accept) begin
      out_valid_d = 1'b1;
      granted_d   = '0;
      unique case (in_i.mode)
        MODE_TICK, MODE_CLEAR: status_d = ST_DONE;
        MODE_REQUEST: begin
          granted_d = grant_handle;
          status_d  = any_grant ? ST_DONE : ST_FAIL;
        end
        MODE_UPDATE: status_d = hit ? ST_DONE : ST_FAIL;
        MODE_CHECK: begin
          if (!hit)          status_d = ST_FAIL;
          else if (counting) status_d = ST_COUNTING;
          else               status_d = ST_TIMEOUT;
        end
        default: status_d = ST_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.granted_handle = granted_q;
  assign out_o.status         = status_q;

endmodule

/* hw/rtl/ctp_checker.sv */
module ctp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ctp_pkg::HANDLE_W-1:0]  granted_handle_i,
  input logic [ctp_pkg::STATUS_W-1:0]  status_i
);
  import ctp_pkg::*;

  // Every accepted transaction yields a result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted transaction produced no result");

  // A granted handle only comes with a successful request.
  a_grant_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && granted_handle_i != '0) |-> (status_i == ST_DONE))
    else $error("granted handle with non-done status");

  // Input is open whenever the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(granted_handle_i) && $stable(status_i)))
    else $error("stalled result changed");

endmodule

bind countdown_timer_pool_top ctp_checker u_ctp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .granted_handle_i (out_o.granted_handle),
  .status_i         (out_o.status)
);

/* test/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  localparam int unsigned POOL_SIZE    = NUM_TIMERS_DEFAULT;
  localparam int unsigned IDX_W        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // Result lands in the cycle after the operation; run on this long after the last one.
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_OPS   = 500;
  localparam int unsigned REPORT_CAP   = 100;
  localparam int unsigned SIDE_SEND    = 0;
  localparam int unsigned SIDE_RECV    = 1;

  // Mode codes that the block does not define.
  localparam logic [MODE_W-1:0] MODE_UNDEF_FIRST = MODE_W'(MODE_CLEAR + 1);
  localparam logic [MODE_W-1:0] MODE_UNDEF_LAST  = '1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  ticks;
  } timer_op_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted;
    status_e             status;
  } timer_result_t;

  // Clock, reset and the values driven onto the channels. Every input
  // starts at a known value at time zero.
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                drv_valid  = 1'b0;
  logic [MODE_W-1:0]   drv_mode   = '0;
  logic [HANDLE_W-1:0] drv_handle = '0;
  logic [TICKS_W-1:0]  drv_ticks  = '0;
  logic                rcv_ready  = 1'b0;

  ctp_in_if  in_if ();
  ctp_out_if out_if ();

  assign in_if.valid  = drv_valid;
  assign in_if.mode   = drv_mode;
  assign in_if.handle = drv_handle;
  assign in_if.ticks  = drv_ticks;
  assign out_if.ready = rcv_ready;

  countdown_timer_pool_top #(
    .NumTimers(POOL_SIZE)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the timer pool, advanced once per accepted operation.
  logic                busy_mark [POOL_SIZE];
  logic [TICKS_W-1:0]  count_left[POOL_SIZE];

  timer_op_t     ops_pending[$];
  timer_result_t results_due[$];

  int unsigned ops_total    = 0;
  int unsigned ops_accepted = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned gen_alloc    = 0;

  // Handshake events seen at the last rising edge, read at the falling edge.
  bit op_taken  = 1'b0;
  bit res_taken = 1'b0;

  // Per-side idling: alternate stretches with no gaps and stretches with
  // random gaps.
  int unsigned phase_left[2] = '{0, 0};
  bit          phase_busy[2] = '{1'b0, 1'b0};
  int unsigned send_wait     = 0;
  int unsigned recv_wait     = 0;

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      busy_mark[i]  = 1'b0;
      count_left[i] = '0;
    end
  end

  function automatic int unsigned draw_wait(input int unsigned side);
    if (phase_left[side] == 0) begin
      phase_busy[side] = ~phase_busy[side];
      phase_left[side] = $urandom_range(8, 48);
    end
    phase_left[side]--;
    return phase_busy[side] ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic bit handle_live(input logic [HANDLE_W-1:0] h);
    if (h == 0 || h > POOL_SIZE) return 1'b0;
    return busy_mark[IDX_W'(h - 1'b1)];
  endfunction

  // Apply one operation to the shadow pool and return the result it owes.
  function automatic timer_result_t timer_pool_apply(input timer_op_t op);
    timer_result_t res;
    int unsigned   reach;
    bit            found;
    res.granted = '0;
    res.status  = ST_FAIL;
    reach       = (POOL_SIZE < MAX_HANDLE) ? POOL_SIZE : MAX_HANDLE;
    found       = 1'b0;
    case (op.mode)
      MODE_TICK: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (busy_mark[i] && count_left[i] != 0) count_left[i] = count_left[i] - 1;
        end
        res.status = ST_DONE;
      end
      MODE_REQUEST: begin
        for (int i = 0; i < reach; i++) begin
          if (!found && !busy_mark[i]) begin
            found         = 1'b1;
            busy_mark[i]  = 1'b1;
            count_left[i] = op.ticks;
            res.granted   = HANDLE_W'(i + 1);
            res.status    = ST_DONE;
          end
        end
      end
      MODE_UPDATE: begin
        if (handle_live(op.handle)) begin
          count_left[IDX_W'(op.handle - 1'b1)] = op.ticks;
          res.status = ST_DONE;
        end
      end
      MODE_CHECK: begin
        if (handle_live(op.handle)) begin
          res.status = (count_left[IDX_W'(op.handle - 1'b1)] != 0) ? ST_COUNTING : ST_TIMEOUT;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          busy_mark[i]  = 1'b0;
          count_left[i] = '0;
        end
        res.status = ST_DONE;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Queue one operation; track how many timers the stream has allocated so
  // that the random part can aim at live handles.
  task automatic push_op(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                         input logic [TICKS_W-1:0] ticks);
    timer_op_t op;
    op.mode   = mode;
    op.handle = handle;
    op.ticks  = ticks;
    ops_pending.push_back(op);
    ops_total++;
    if (mode == MODE_REQUEST && gen_alloc < POOL_SIZE) gen_alloc++;
    if (mode == MODE_CLEAR) gen_alloc = 0;
  endtask

  // Mostly live handles; some zero, some free, some out of range.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78 && gen_alloc > 0) return HANDLE_W'($urandom_range(1, gen_alloc));
    if (r < 86) return '0;
    if (r < 93 && gen_alloc < POOL_SIZE)
      return HANDLE_W'($urandom_range(gen_alloc + 1, POOL_SIZE));
    return HANDLE_W'($urandom_range(POOL_SIZE + 1, MAX_HANDLE));
  endfunction

  // Small counts so that ticks drive timers to zero, plus wide values.
  function automatic logic [TICKS_W-1:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 55) return $urandom_range(1, 4);
    if (r < 75) return $urandom_range(5, 40);
    if (r < 90) return $urandom;
    return '1 - $urandom_range(0, 3);
  endfunction

  function automatic logic [HANDLE_W-1:0] any_handle();
    return HANDLE_W'($urandom);
  endfunction

  task automatic push_mixed_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30)      push_op(MODE_TICK, any_handle(), $urandom);
    else if (r < 50) push_op(MODE_REQUEST, any_handle(), pick_ticks());
    else if (r < 65) push_op(MODE_UPDATE, pick_handle(), pick_ticks());
    else if (r < 95) push_op(MODE_CHECK, pick_handle(), $urandom);
    else if (r < 98)
      push_op(MODE_W'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST)), any_handle(),
              $urandom);
    else             push_op(MODE_CLEAR, any_handle(), $urandom);
  endtask

  // Stimulus: directed opening, then random episodes that fill the pool,
  // work it and clear it.
  initial begin
    // Empty pool: every handle is invalid, tick still succeeds, undefined modes fail.
    push_op(MODE_CHECK, '0, '0);
    push_op(MODE_CHECK, 5'd1, '0);
    push_op(MODE_UPDATE, 5'd1, 32'd7);
    push_op(MODE_TICK, '0, '0);
    for (int m = MODE_UNDEF_FIRST; m <= MODE_UNDEF_LAST; m++) begin
      push_op(MODE_W'(m), '1, '1);
    end
    // Zero count, full count and a one-tick count.
    push_op(MODE_REQUEST, '1, '0);
    push_op(MODE_REQUEST, '0, '1);
    push_op(MODE_REQUEST, '0, 32'd1);
    push_op(MODE_CHECK, 5'd1, '0);
    push_op(MODE_CHECK, 5'd2, '0);
    push_op(MODE_CHECK, 5'd3, '1);
    push_op(MODE_TICK, '1, '1);
    push_op(MODE_CHECK, 5'd3, '0);
    push_op(MODE_UPDATE, 5'd2, '0);
    push_op(MODE_CHECK, 5'd2, '0);
    // Out-of-range and zero handles.
    push_op(MODE_UPDATE, HANDLE_W'(POOL_SIZE + 1), 32'd3);
    push_op(MODE_CHECK, '1, '0);
    push_op(MODE_UPDATE, '0, 32'd3);
    push_op(MODE_UPDATE, 5'd3, 32'h8000_0000);
    push_op(MODE_CLEAR, '0, '0);
    push_op(MODE_CHECK, 5'd2, '0);
    push_op(MODE_REQUEST, '0, 32'd2);
    push_op(MODE_TICK, '0, '0);

    while (ops_total < RANDOM_OPS + 25) begin
      // Exhaust the pool now and then so that a request finds nothing free.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(POOL_SIZE + 1, POOL_SIZE + 4)) begin
          push_op(MODE_REQUEST, any_handle(), pick_ticks());
        end
      end
      repeat ($urandom_range(20, 60)) push_mixed_op();
      push_op(MODE_CLEAR, any_handle(), $urandom);
    end
  end

  // Hold reset low at start, release it away from the rising edge.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Sender: hold each transaction until it is taken, then wait the drawn
  // gap before the next one.
  always @(negedge clk_i) begin
    timer_op_t op;
    if (rst_ni) begin
      if (drv_valid && !op_taken) begin
        // hold
      end else if (send_wait > 0) begin
        drv_valid <= 1'b0;
        send_wait--;
      end else if (ops_pending.size() > 0) begin
        op = ops_pending.pop_front();
        drv_valid  <= 1'b1;
        drv_mode   <= op.mode;
        drv_handle <= op.handle;
        drv_ticks  <= op.ticks;
        send_wait  = draw_wait(SIDE_SEND);
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: after each result taken, stall for the drawn number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) recv_wait = draw_wait(SIDE_RECV);
      if (recv_wait > 0) begin
        rcv_ready <= 1'b0;
        recv_wait--;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  // Monitor: check the result leaving first, then advance the shadow pool
  // with the operation entering, so a result never meets its own prediction
  // in the same edge.
  always @(posedge clk_i) begin
    timer_op_t     op;
    timer_result_t want;
    op_taken  = 1'b0;
    res_taken = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        res_taken = 1'b1;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result handle=%0d status=%0d with nothing outstanding",
                                    out_if.granted_handle, out_if.status));
        end else begin
          want = results_due.pop_front();
          if (out_if.granted_handle !== want.granted)
            report_mismatch($sformatf("granted_handle %0d, want %0d",
                                      out_if.granted_handle, want.granted));
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
        end
      end
      if (in_if.valid && in_if.ready) begin
        op_taken  = 1'b1;
        op.mode   = in_if.mode;
        op.handle = in_if.handle;
        op.ticks  = in_if.ticks;
        results_due.push_back(timer_pool_apply(op));
        ops_accepted++;
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // End of run: all operations taken, all results back, then drain for
  // DRAIN_CYCLES to catch anything extra.
  initial begin
    @(posedge rst_ni);
    while (ops_total == 0 || ops_accepted < ops_total || results_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/ctp_pkg.sv
hw/rtl/ctp_if.sv
hw/rtl/ctp_cell.sv
hw/rtl/countdown_timer_pool_top.sv
hw/rtl/ctp_checker.sv
test/testbench.sv
